// ===== src/pfdc_pkg.sv =====
package pfdc_pkg;

  localparam int unsigned GRID_N   = 5;
  localparam int unsigned CODE_W   = 5;
  localparam int unsigned ROW_W    = GRID_N * CODE_W;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FOUR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;

  localparam logic [BYTE_W-1:0] CHAR_UA  = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] CHAR_UZ  = 8'h5A;  // 'Z'
  localparam logic [BYTE_W-1:0] CHAR_LA  = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CHAR_LZ  = 8'h7A;  // 'z'
  localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;
  localparam logic [CODE_W-1:0] CODE_J   = 5'd9;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [GRID_N-1:0][ROW_W-1:0] grid_t;

  // the two bytes of a pair, as they enter or leave the substitution
  typedef struct packed {
    byte_t first;
    byte_t second;
  } pair_t;

  function automatic byte_t to_upper(input byte_t b);
    byte_t u;
    u = b;
    if (b >= CHAR_LA && b <= CHAR_LZ) begin
      u = b - CASE_GAP;
    end
    return u;
  endfunction

endpackage

// ===== src/pfdc_pair_sub.sv =====
module pfdc_pair_sub (
  input  pfdc_pkg::grid_t grid,
  input  logic            decipher,
  input  pfdc_pkg::pair_t pair_in,
  output pfdc_pkg::pair_t pair_out
);
  import pfdc_pkg::*;

  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } loc_t;

  function automatic loc_t find_cell(input grid_t g, input code_t code);
    loc_t l;
    l = '0;
    // descending scan so the lowest row, then lowest column, wins
    for (int r = GRID_N - 1; r >= 0; r--) begin
      for (int c = GRID_N - 1; c >= 0; c--) begin
        if (g[r][c*CODE_W +: CODE_W] == code) begin
          l.found = 1'b1;
          l.row   = IDX_W'(r);
          l.col   = IDX_W'(c);
        end
      end
    end
    return l;
  endfunction

  function automatic idx_t step_idx(input idx_t x, input logic dec);
    idx_t y;
    if (dec) begin
      y = (x == '0) ? IDX_W'(GRID_N - 1) : x - 1'b1;
    end else begin
      y = (x == IDX_W'(GRID_N - 1)) ? '0 : x + 1'b1;
    end
    return y;
  endfunction

  function automatic byte_t letter_at(input grid_t g, input idx_t row, input idx_t col);
    code_t code;
    code = '0;
    for (int r = 0; r < GRID_N; r++) begin
      for (int c = 0; c < GRID_N; c++) begin
        if (row == IDX_W'(r) && col == IDX_W'(c)) begin
          code = g[r][c*CODE_W +: CODE_W];
        end
      end
    end
    return CHAR_UA + {{(BYTE_W-CODE_W){1'b0}}, code};
  endfunction

  byte_t a;
  byte_t b;
  code_t code_a;
  code_t code_b;
  loc_t  loc_a;
  loc_t  loc_b;
  logic  both_letters;
  logic  usable;

  assign a      = pair_in.first;
  assign b      = pair_in.second;
  assign code_a = CODE_W'(a - CHAR_UA);
  assign code_b = CODE_W'(b - CHAR_UA);
  assign loc_a  = find_cell(grid, code_a);
  assign loc_b  = find_cell(grid, code_b);

  assign both_letters = (a >= CHAR_UA) && (a <= CHAR_UZ) && (b >= CHAR_UA) && (b <= CHAR_UZ);
  assign usable = both_letters && (code_a != CODE_J) && (code_b != CODE_J) &&
                  loc_a.found && loc_b.found;

  always_comb begin
    pair_out = pair_in;
    if (usable) begin
      if (loc_a.col == loc_b.col) begin
        pair_out.first  = letter_at(grid, step_idx(loc_a.row, decipher), loc_a.col);
        pair_out.second = letter_at(grid, step_idx(loc_b.row, decipher), loc_b.col);
      end else if (loc_a.row == loc_b.row) begin
        pair_out.first  = letter_at(grid, loc_a.row, step_idx(loc_a.col, decipher));
        pair_out.second = letter_at(grid, loc_b.row, step_idx(loc_b.col, decipher));
      end else begin
        pair_out.first  = letter_at(grid, loc_a.row, loc_b.col);
        pair_out.second = letter_at(grid, loc_b.row, loc_a.col);
      end
    end
  end

endmodule

// ===== src/playfair_digraph_cipher_unit.sv =====
// Playfair digraph unit: message bytes stream in one per cycle unless
// in_tready holds them off, and are uppercased (a-z only). Bytes pair up
// by position: the first byte of a pair is held and yields nothing, the
// second releases both bytes, Playfair substituted against the 5x5 grid
// in registers 0-4 when both are letters other than J found in the grid,
// else passed through. A lone byte closing the message (tlast with nothing
// held) comes out on its own. out_tuser flags the last result of the
// request that caused it, out_tlast the final byte of the message. A
// request is registered on entry and its results are then registered in a
// two-entry result queue once it has room, so one request is taken every
// cycle while the sink keeps up; a pair's two results leave one after the
// other while the opening byte of the next pair is taken. decipher_mode
// (register 5) picks shift -1 instead of +1. The user must see that
// configuration is written only while the unit is idle; not enforced.
module playfair_digraph_cipher_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // message input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] in_byte
  input  logic                                 in_tlast,   // in_last
  // result output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // [7:0] out_byte
  output logic                                 out_tuser,  // [0] run_last
  output logic                                 out_tlast,  // message_end
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pfdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfdc_pkg::ROW_W-1:0]           cfg_data
);
  import pfdc_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  msg_end;
  } res_t;

  // configuration registers
  grid_t grid_r;
  logic  mode_r;

  // input register
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // pair state
  logic  holding_r;
  logic  holding_nxt;
  byte_t held_r;
  byte_t held_nxt;

  // result queue, entry 0 is the head
  res_t       q_r   [2];
  res_t       q_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_left;

  logic  pop;
  logic  can_take;
  logic  s1_take;
  pair_t pair_in;
  pair_t pair_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= '0;
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_ZERO:  grid_r[0] <= cfg_data;
        REG_ROW_ONE:   grid_r[1] <= cfg_data;
        REG_ROW_TWO:   grid_r[2] <= cfg_data;
        REG_ROW_THREE: grid_r[3] <= cfg_data;
        REG_ROW_FOUR:  grid_r[4] <= cfg_data;
        REG_MODE:      mode_r    <= cfg_data[0];
        default:       ;  // unmapped index, write dropped
      endcase
    end
  end

  // output side
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[0].data;
  assign out_tuser  = q_r[0].run_last;
  assign out_tlast  = q_r[0].msg_end;
  assign pop        = out_tvalid && out_tready;
  assign cnt_left   = pop ? cnt_r - 2'd1 : cnt_r;

  // a closing byte needs room for two results, an opening byte for one
  assign can_take  = holding_r ? (cnt_left == 2'd0) : (cnt_left != 2'd2);
  assign s1_take   = s1_valid_r && can_take;
  assign in_tready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= to_upper(in_tdata);
      s1_last_r <= in_tlast;
    end
  end

  assign pair_in.first  = held_r;
  assign pair_in.second = s1_byte_r;

  pfdc_pair_sub u_pair_sub (
    .grid     (grid_r),
    .decipher (mode_r),
    .pair_in  (pair_in),
    .pair_out (pair_out)
  );

  always_comb begin
    q_nxt[0]    = pop ? q_r[1] : q_r[0];
    q_nxt[1]    = q_r[1];
    cnt_nxt     = cnt_left;
    holding_nxt = holding_r;
    held_nxt    = held_r;
    if (s1_take) begin
      if (holding_r) begin
        // pair closes: both bytes go out, queue is empty here
        q_nxt[0]    = '{data: pair_out.first,  run_last: 1'b0, msg_end: 1'b0};
        q_nxt[1]    = '{data: pair_out.second, run_last: 1'b1, msg_end: s1_last_r};
        cnt_nxt     = 2'd2;
        holding_nxt = 1'b0;
        held_nxt    = '0;
      end else if (s1_last_r) begin
        // lone byte at message end
        if (cnt_left == 2'd0) begin
          q_nxt[0] = '{data: s1_byte_r, run_last: 1'b1, msg_end: 1'b1};
        end else begin
          q_nxt[1] = '{data: s1_byte_r, run_last: 1'b1, msg_end: 1'b1};
        end
        cnt_nxt = cnt_left + 2'd1;
      end else begin
        holding_nxt = 1'b1;
        held_nxt    = s1_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 2'd0;
      holding_r <= 1'b0;
      held_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      holding_r <= holding_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  // queue never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  // a closing byte only enters with the queue drained
  a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && holding_r) |-> (cnt_left == 2'd0))
    else $error("pair taken without room for two results");

  // closing a pair always leaves two results and nothing held
  a_pair_close: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && holding_r) |=> (!holding_r && cnt_r == 2'd2 && q_r[1].run_last))
    else $error("pair close did not queue two results");

endmodule

// ===== tb/tb_playfair_digraph_cipher_unit.sv =====
module tb_playfair_digraph_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfdc_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int DRAIN_CYCLES    = 8;    // pipeline is two deep, leave some margin
  localparam int HOLD_OFF_CYCLES = 90;   // long sink stall for the back-pressure phase
  localparam int MAX_REPORTS     = 100;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;
  localparam logic [CFG_IDX_W-1:0] ROW_REGS [GRID_N] =
    '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO, REG_ROW_THREE, REG_ROW_FOUR};

  // textbook square for the key PLAYFAIR EXAMPLE, row 0 first
  localparam string STD_SQUARE = "PLAYFIREXMBCDGHKNOQSTUVWZ";

  typedef enum logic [1:0] {SETUP_KEEP, SETUP_STD_ENC, SETUP_STD_DEC} setup_e;
  typedef enum logic [2:0] {GRID_STD, GRID_SHUFFLED, GRID_RAW, GRID_ONES, GRID_ZEROS} grid_kind_e;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  msg_end;
  } cipher_out_t;

  // one directed request; typed rows carry the bytes read straight off the spec
  typedef struct packed {
    setup_e setup;
    byte_t  data;
    logic   last;
    logic   typed;
    byte_t  exp_first;
    byte_t  exp_second;
  } stim_row_t;

  typedef struct packed {
    grid_kind_e kind;
    logic       mode;
    logic       spares;
    logic       pressure;
    logic [6:0] send_idle;
    logic [6:0] recv_stall;
    logic [9:0] count;
  } phase_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;  // [7:0] in_byte
  logic                 in_tlast   = 1'b0;  // in_last
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;  // [7:0] out_byte
  logic                 out_tuser;  // [0] run_last
  logic                 out_tlast;  // message_end
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [ROW_W-1:0]     cfg_data   = '0;

  // shadow of the unit's registers and pair state
  logic [ROW_W-1:0] grid_shadow [GRID_N] = '{default: '0};
  logic             decipher_shadow      = 1'b0;
  byte_t            held_shadow          = '0;
  logic             holding_shadow       = 1'b0;
  cipher_out_t      pair_results [2];

  cipher_out_t      pending_bytes [$];
  int               mismatch_count = 0;
  int               send_idle_pct  = 0;
  int               stall_pct      = 0;
  int               hold_req       = 0;
  int               hold_served    = 0;
  int               hold_left      = 0;

  // directed requests: reset grid first (every cell reads A), then the textbook square
  stim_row_t directed_rows [0:24] = '{
    '{SETUP_KEEP,    "A",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "a",   1'b0, 1'b1, "A",   "A"  },  // both found at the first match, cell (0,0), same column
    '{SETUP_KEEP,    8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    8'hFF, 1'b0, 1'b1, 8'h00, 8'hFF},  // byte extremes pass through
    '{SETUP_KEEP,    "z",   1'b1, 1'b1, "Z",   8'h00},  // lone byte closing a message
    '{SETUP_KEEP,    "B",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    8'h80, 1'b1, 1'b1, "B",   8'h80},  // pair closed by the last byte
    '{SETUP_KEEP,    "{",   1'b1, 1'b1, "{",   8'h00},  // just past z, not uppercased
    '{SETUP_STD_ENC, "H",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "I",   1'b0, 1'b0, 8'h00, 8'h00},  // rectangle
    '{SETUP_KEEP,    "D",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "e",   1'b0, 1'b0, 8'h00, 8'h00},  // same column
    '{SETUP_KEEP,    "P",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "F",   1'b0, 1'b0, 8'h00, 8'h00},  // same row with wrap
    '{SETUP_KEEP,    "E",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "E",   1'b0, 1'b0, 8'h00, 8'h00},  // doubled letter
    '{SETUP_KEEP,    "J",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "A",   1'b0, 1'b1, "J",   "A"  },  // J never substituted
    '{SETUP_KEEP,    "Z",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "@",   1'b1, 1'b1, "Z",   "@"  },  // just below A
    '{SETUP_STD_DEC, "B",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "M",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "O",   1'b0, 1'b0, 8'h00, 8'h00},
    '{SETUP_KEEP,    "D",   1'b1, 1'b0, 8'h00, 8'h00},  // decipher shift within a column, closes message
    '{SETUP_KEEP,    "L",   1'b1, 1'b1, "L",   8'h00}
  };

  // random phases: grid kind, mode, spare writes, hold-off, idle percentages, requests
  phase_t phase_plan [0:6] = '{
    '{GRID_SHUFFLED, 1'b0, 1'b0, 1'b0, 7'd0,  7'd0,  10'd150},
    '{GRID_STD,      1'b1, 1'b0, 1'b0, 7'd72, 7'd0,  10'd140},
    '{GRID_SHUFFLED, 1'b1, 1'b0, 1'b0, 7'd0,  7'd72, 10'd140},
    '{GRID_RAW,      1'b0, 1'b1, 1'b0, 7'd7,  7'd7,  10'd140},
    '{GRID_SHUFFLED, 1'b0, 1'b0, 1'b1, 7'd0,  7'd0,  10'd120},
    '{GRID_ONES,     1'b1, 1'b0, 1'b0, 7'd7,  7'd7,  10'd50},
    '{GRID_SHUFFLED, 1'b1, 1'b1, 1'b0, 7'd30, 7'd30, 10'd110}
  };

  playfair_digraph_cipher_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // playfair prediction
  // ---------------------------------------------------------------------------

  function automatic byte_t upcase(byte_t b);
    if (b >= CHAR_LA && b <= CHAR_LZ) begin
      return byte_t'(b - CASE_GAP);
    end
    return b;
  endfunction

  function automatic code_t grid_cell(int r, int k);
    return grid_shadow[r % GRID_N][CODE_W*(k % GRID_N) +: CODE_W];
  endfunction

  // first match wins, row-major scan; codes 26-31 never match a letter
  function automatic bit locate_letter(code_t c, output int r, output int k);
    r = 0;
    k = 0;
    for (int i = 0; i < GRID_N*GRID_N; i++) begin
      if (grid_cell(i / GRID_N, i % GRID_N) == c) begin
        r = i / GRID_N;
        k = i % GRID_N;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic byte_t letter_at(int r, int k);
    return byte_t'(CHAR_UA + grid_cell(r, k));
  endfunction

  // advance the pair state by one request, results go to pair_results
  function automatic int playfair_step(byte_t raw, logic last);
    byte_t b, a, oa, ob;
    int    ra, ka, rb, kb, sh;
    bit    found;
    b = upcase(raw);
    if (!holding_shadow) begin
      if (last) begin
        pair_results[0] = '{b, 1'b1, 1'b1};
        return 1;
      end
      held_shadow    = b;
      holding_shadow = 1'b1;
      return 0;
    end
    a  = held_shadow;
    oa = a;
    ob = b;
    found = a >= CHAR_UA && a <= CHAR_UZ && b >= CHAR_UA && b <= CHAR_UZ &&
            code_t'(a - CHAR_UA) != CODE_J && code_t'(b - CHAR_UA) != CODE_J;
    if (found) found = locate_letter(code_t'(a - CHAR_UA), ra, ka);
    if (found) found = locate_letter(code_t'(b - CHAR_UA), rb, kb);
    if (found) begin
      sh = decipher_shadow ? GRID_N - 1 : 1;
      if (ka == kb) begin
        oa = letter_at(ra + sh, ka);
        ob = letter_at(rb + sh, kb);
      end else if (ra == rb) begin
        oa = letter_at(ra, ka + sh);
        ob = letter_at(rb, kb + sh);
      end else begin
        oa = letter_at(ra, kb);
        ob = letter_at(rb, ka);
      end
    end
    holding_shadow  = 1'b0;
    held_shadow     = '0;
    pair_results[0] = '{oa, 1'b0, 1'b0};
    pair_results[1] = '{ob, 1'b1, last};
    return 2;
  endfunction

  // mostly letters of the current grid so pairs get substituted, the rest noise
  function automatic byte_t pick_message_byte();
    int    p;
    code_t c;
    p = $urandom_range(99);
    c = grid_cell($urandom_range(GRID_N - 1), $urandom_range(GRID_N - 1));
    if (c > 5'd25) c = code_t'($urandom_range(25));
    if (p < 60) return byte_t'(CHAR_UA + c);
    if (p < 75) return byte_t'(CHAR_LA + c);
    if (p < 88) return byte_t'(CHAR_UA + $urandom_range(25));
    return byte_t'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // request and register drivers
  // ---------------------------------------------------------------------------

  // send one message byte, then queue the results it releases
  task automatic issue_byte(byte_t b, logic last, logic typed, byte_t exp_first,
                            byte_t exp_second);
    int          n;
    cipher_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n = playfair_step(b, last);
    for (int i = 0; i < n; i++) begin
      r = pair_results[i];
      if (typed) r.data = (i == 0) ? exp_first : exp_second;
      pending_bytes.push_back(r);
    end
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_ROW_FOUR) begin
      grid_shadow[idx] = value;
    end else if (idx == REG_MODE) begin
      decipher_shadow = value[0];
    end
  endtask

  task automatic load_grid(grid_kind_e kind, logic mode, logic spares);
    code_t            cells [GRID_N*GRID_N];
    code_t            t;
    int               j;
    logic [ROW_W-1:0] row;
    // all letters but J, in textbook order for GRID_STD, shuffled for GRID_SHUFFLED
    for (int i = 0; i < GRID_N*GRID_N; i++) begin
      cells[i] = (kind == GRID_STD) ? code_t'(STD_SQUARE[i] - CHAR_UA)
                                    : code_t'((i < CODE_J) ? i : i + 1);
    end
    if (kind == GRID_SHUFFLED) begin
      for (int i = GRID_N*GRID_N - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        t        = cells[i];
        cells[i] = cells[j];
        cells[j] = t;
      end
    end
    for (int r = 0; r < GRID_N; r++) begin
      row = '0;
      for (int k = 0; k < GRID_N; k++) row[CODE_W*k +: CODE_W] = cells[GRID_N*r + k];
      case (kind)
        GRID_RAW:   row = ROW_W'($urandom);  // duplicates, J and dead codes all possible
        GRID_ONES:  row = '1;
        GRID_ZEROS: row = '0;
        default: ;
      endcase
      write_reg(ROW_REGS[r], row);
    end
    write_reg(REG_MODE, ROW_W'(mode));
    if (spares) begin
      write_reg(REG_SPARE_SIX, ROW_W'($urandom));
      write_reg(REG_SPARE_SEVEN, '1);
    end
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every queued result and let the pipeline empty
  task automatic drain_unit();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sink: random stalls plus a long hold-off on request from the stimulus
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      out_tready  <= 1'b0;
      hold_served <= hold_req;
      hold_left   <= HOLD_OFF_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted byte against the oldest queued expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cipher_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser, out_tlast};
      if (pending_bytes.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual byte %h run_last %b end %b",
                   $time, got.data, got.run_last, got.msg_end);
        end
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data || got.run_last !== want.run_last ||
            got.msg_end !== want.msg_end) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch: expected byte %h run_last %b end %b, actual byte %h run_last %b end %b",
                     $time, want.data, want.run_last, want.msg_end,
                     got.data, got.run_last, got.msg_end);
          end
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    byte_t b;
    logic  last;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset registers first
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setup != SETUP_KEEP) begin
        drain_unit();
        load_grid(GRID_STD, directed_rows[i].setup == SETUP_STD_DEC, 1'b0);
      end
      issue_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                 directed_rows[i].exp_first, directed_rows[i].exp_second);
    end

    // random phases, each ends on a message end so no byte is held across a write
    foreach (phase_plan[p]) begin
      drain_unit();
      load_grid(phase_plan[p].kind, phase_plan[p].mode, phase_plan[p].spares);
      send_idle_pct = phase_plan[p].send_idle;
      stall_pct    <= phase_plan[p].recv_stall;
      if (phase_plan[p].pressure) hold_req <= hold_req + 1;
      for (int n = 0; n < phase_plan[p].count; n++) begin
        b    = pick_message_byte();
        last = (n == phase_plan[p].count - 1) || ($urandom_range(11) == 0);
        issue_byte(b, last, 1'b0, '0, '0);
      end
    end

    drain_unit();
    if (mismatch_count == 0) begin
      $display("playfair_digraph_cipher_unit test passed");
    end else begin
      $display("playfair_digraph_cipher_unit test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("playfair_digraph_cipher_unit test failed");
    $finish;
  end

endmodule
